>>> rtl/core/spp_pkg.sv
package spp_pkg;

    localparam int DEF_MAX_BANDS = 64;

    localparam int CB_W    = 4;
    localparam int START_W = 6;
    localparam int BAND_W  = 7;
    localparam int INC_W   = 5;
    localparam int BCNT_W  = 3;
    localparam int ERR_W   = 2;

    localparam logic [INC_W-1:0]  ESC_SHORT   = 5'd7;
    localparam logic [INC_W-1:0]  ESC_LONG    = 5'd31;
    localparam logic [BCNT_W-1:0] NBITS_SHORT = 3'd3;
    localparam logic [BCNT_W-1:0] NBITS_LONG  = 3'd5;
    localparam logic [BCNT_W-1:0] CB_LAST_BIT = 3'd3;
    localparam logic [CB_W-1:0]   CB_MAX      = 4'd11;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_BIT   = 1'b1;

    localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
    localparam logic [ERR_W-1:0] ERR_CODEBOOK = 2'd1;
    localparam logic [ERR_W-1:0] ERR_PAST_MAX = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_CODEBOOK = 2'd1,
        PH_LENGTH   = 2'd2
    } t_phase;

    typedef struct packed {
        logic               action;
        logic               stream_bit;
        logic [START_W-1:0] max_bands;
        logic [BAND_W-1:0]  band_count;
        logic               short_transform;
    } t_in_item;

    typedef struct packed {
        logic               section_valid;
        logic [CB_W-1:0]    section_codebook;
        logic [START_W-1:0] section_start;
        logic [BAND_W-1:0]  section_end;
        logic               group_done;
        logic [BAND_W-1:0]  limit_sections;
        logic [ERR_W-1:0]   error_code;
    } t_result;

endpackage

>>> rtl/core/spp_in_if.sv
interface spp_in_if
    import spp_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               action;
    logic               stream_bit;
    logic [START_W-1:0] max_bands;
    logic [BAND_W-1:0]  band_count;
    logic               short_transform;

    modport source (
        output valid, action, stream_bit, max_bands, band_count, short_transform,
        input  ready
    );
    modport sink (
        input  valid, action, stream_bit, max_bands, band_count, short_transform,
        output ready
    );
endinterface

>>> rtl/core/spp_out_if.sv
interface spp_out_if
    import spp_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               section_valid;
    logic [CB_W-1:0]    section_codebook;
    logic [START_W-1:0] section_start;
    logic [BAND_W-1:0]  section_end;
    logic               group_done;
    logic [BAND_W-1:0]  limit_sections;
    logic [ERR_W-1:0]   error_code;

    modport source (
        output valid, section_valid, section_codebook, section_start, section_end,
               group_done, limit_sections, error_code,
        input  ready
    );
    modport sink (
        input  valid, section_valid, section_codebook, section_start, section_end,
               group_done, limit_sections, error_code,
        output ready
    );
endinterface

>>> rtl/core/spp_in_stage.sv
module spp_in_stage
    import spp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    input  logic     i_take,
    output logic     o_adv,
    output t_in_item o_item
);
    logic     r_valid;
    t_in_item r_item;

    assign o_adv   = r_valid && i_take;
    assign o_ready = !r_valid || o_adv;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end
endmodule

>>> rtl/core/spp_parse_core.sv
module spp_parse_core
    import spp_pkg::*;
#(
    parameter int MAX_BANDS = DEF_MAX_BANDS
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_adv,
    input  t_in_item i_item,
    output logic     o_res_fire,
    output t_result  o_res
);
    t_phase              r_phase, n_phase;
    logic [BCNT_W-1:0]   r_bit_count, n_bit_count;
    logic [CB_W-1:0]     r_cb_shift, n_cb_shift;
    logic [INC_W-1:0]    r_inc_shift, n_inc_shift;
    logic [BAND_W-1:0]   r_len_acc, n_len_acc;
    logic [BAND_W-1:0]   r_band_pos, n_band_pos;
    logic [BAND_W-1:0]   r_sec_count, n_sec_count;
    logic [BAND_W-1:0]   r_limit_count, n_limit_count;
    logic [START_W-1:0]  r_max_b, n_max_b;
    logic [BAND_W-1:0]   r_bands, n_bands;
    logic                r_short, n_short;

    logic [START_W-1:0]  max_clamp;
    logic [BAND_W-1:0]   bands_clamp;
    logic [BCNT_W-1:0]   nbits;
    logic [INC_W-1:0]    esc;
    logic [INC_W-1:0]    inc_new;
    logic [BCNT_W-1:0]   bc_new;
    logic [INC_W-1:0]    incr;
    logic                inc_done;
    logic                is_esc;
    logic [BAND_W:0]     acc_sum;
    logic [BAND_W-1:0]   acc_sat;
    logic [BAND_W:0]     len_sum;
    logic [BAND_W-1:0]   len_sat;
    logic [BAND_W:0]     end_sum;
    logic [BAND_W-1:0]   sec_new;
    logic [BAND_W-1:0]   limit_new;
    logic                hit_limit;
    logic                cb_bad;
    logic                past_max;
    logic                at_max;
    logic                start_empty;

    // Datapath terms
    always_comb begin
        max_clamp   = ({2'b00, i_item.max_bands} > 8'(MAX_BANDS)) ?
                      START_W'(MAX_BANDS) : i_item.max_bands;
        bands_clamp = ({1'b0, i_item.band_count} > 8'(MAX_BANDS)) ?
                      BAND_W'(MAX_BANDS) : i_item.band_count;
        start_empty = (max_clamp == '0);
        nbits       = r_short ? NBITS_SHORT : NBITS_LONG;
        esc         = r_short ? ESC_SHORT : ESC_LONG;
        inc_new     = {r_inc_shift[INC_W-2:0], i_item.stream_bit};
        bc_new      = r_bit_count + 1'b1;
        inc_done    = (bc_new >= nbits);
        incr        = inc_new & esc;
        is_esc      = (incr == esc);
        acc_sum     = {1'b0, r_len_acc} + {3'b000, esc};
        acc_sat     = acc_sum[BAND_W] ? '1 : acc_sum[BAND_W-1:0];
        len_sum     = {1'b0, r_len_acc} + {3'b000, incr};
        len_sat     = len_sum[BAND_W] ? '1 : len_sum[BAND_W-1:0];
        end_sum     = {1'b0, r_band_pos} + {1'b0, len_sat};
        cb_bad      = (r_cb_shift > CB_MAX);
        past_max    = (end_sum > {2'b00, r_max_b});
        at_max      = (end_sum == {2'b00, r_max_b});
        sec_new     = r_sec_count + 1'b1;
        hit_limit   = (r_band_pos < r_bands) && (end_sum[BAND_W-1:0] >= r_bands);
        limit_new   = hit_limit ? sec_new : r_limit_count;
    end

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (i_item.action == ACT_START) begin
            n_phase = start_empty ? PH_IDLE : PH_CODEBOOK;
        end else begin
            case (r_phase)
                PH_CODEBOOK: begin
                    if (r_bit_count == CB_LAST_BIT) begin
                        n_phase = PH_LENGTH;
                    end
                end
                PH_LENGTH: begin
                    if (inc_done && !is_esc) begin
                        n_phase = (cb_bad || past_max || at_max) ? PH_IDLE : PH_CODEBOOK;
                    end
                end
                default: n_phase = r_phase;
            endcase
        end
    end

    // Next datapath state
    always_comb begin
        n_bit_count   = r_bit_count;
        n_cb_shift    = r_cb_shift;
        n_inc_shift   = r_inc_shift;
        n_len_acc     = r_len_acc;
        n_band_pos    = r_band_pos;
        n_sec_count   = r_sec_count;
        n_limit_count = r_limit_count;
        n_max_b       = r_max_b;
        n_bands       = r_bands;
        n_short       = r_short;
        if (i_item.action == ACT_START) begin
            n_max_b       = max_clamp;
            n_bands       = bands_clamp;
            n_short       = i_item.short_transform;
            n_band_pos    = '0;
            n_sec_count   = '0;
            n_limit_count = '0;
            n_bit_count   = '0;
            n_cb_shift    = '0;
            n_inc_shift   = '0;
            n_len_acc     = BAND_W'(1);
        end else begin
            case (r_phase)
                PH_CODEBOOK: begin
                    n_cb_shift = {r_cb_shift[CB_W-2:0], i_item.stream_bit};
                    if (r_bit_count == CB_LAST_BIT) begin
                        n_bit_count = '0;
                        n_inc_shift = '0;
                        n_len_acc   = BAND_W'(1);
                    end else begin
                        n_bit_count = bc_new;
                    end
                end
                PH_LENGTH: begin
                    if (!inc_done) begin
                        n_inc_shift = inc_new;
                        n_bit_count = bc_new;
                    end else begin
                        n_inc_shift = '0;
                        n_bit_count = '0;
                        if (is_esc) begin
                            n_len_acc = acc_sat;
                        end else begin
                            n_len_acc = BAND_W'(1);
                            if (!cb_bad && !past_max) begin
                                n_sec_count   = sec_new;
                                n_limit_count = limit_new;
                                n_band_pos    = end_sum[BAND_W-1:0];
                                n_cb_shift    = '0;
                            end
                        end
                    end
                end
                default: n_bit_count = r_bit_count;
            endcase
        end
    end

    // Result
    always_comb begin
        o_res_fire = 1'b0;
        o_res      = '0;
        if (i_item.action == ACT_START) begin
            if (start_empty) begin
                o_res_fire       = 1'b1;
                o_res.group_done = 1'b1;
            end
        end else if (r_phase == PH_LENGTH && inc_done && !is_esc) begin
            o_res_fire = 1'b1;
            if (cb_bad) begin
                o_res.group_done = 1'b1;
                o_res.error_code = ERR_CODEBOOK;
            end else if (past_max) begin
                o_res.group_done = 1'b1;
                o_res.error_code = ERR_PAST_MAX;
            end else begin
                o_res.section_valid    = 1'b1;
                o_res.section_codebook = r_cb_shift;
                o_res.section_start    = r_band_pos[START_W-1:0];
                o_res.section_end      = end_sum[BAND_W-1:0];
                if (at_max) begin
                    o_res.group_done     = 1'b1;
                    o_res.limit_sections = (limit_new != '0) ? limit_new : sec_new;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_bit_count   <= '0;
            r_cb_shift    <= '0;
            r_inc_shift   <= '0;
            r_len_acc     <= BAND_W'(1);
            r_band_pos    <= '0;
            r_sec_count   <= '0;
            r_limit_count <= '0;
            r_max_b       <= '0;
            r_bands       <= '0;
            r_short       <= 1'b0;
        end else if (i_adv) begin
            r_phase       <= n_phase;
            r_bit_count   <= n_bit_count;
            r_cb_shift    <= n_cb_shift;
            r_inc_shift   <= n_inc_shift;
            r_len_acc     <= n_len_acc;
            r_band_pos    <= n_band_pos;
            r_sec_count   <= n_sec_count;
            r_limit_count <= n_limit_count;
            r_max_b       <= n_max_b;
            r_bands       <= n_bands;
            r_short       <= n_short;
        end
    end
endmodule

>>> rtl/core/spp_out_stage.sv
module spp_out_stage
    import spp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_adv,
    input  logic    i_fire,
    input  t_result i_res,
    output logic    o_take,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);
    logic    r_valid;
    t_result r_res;

    assign o_take  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_fire;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_fire) begin
            r_res <= i_res;
        end
    end
endmodule

>>> rtl/core/spectral_section_parser.sv
// Channel  Dir  Payload                                              Transaction
// i_in     in   action, stream_bit, max_bands, band_count,           valid && ready
//               short_transform
// o_out    out  section_valid, section_codebook, section_start,      valid && ready
//               section_end, group_done, limit_sections, error_code
//
// One transaction per clock when the result sink is ready: an item waits in the
// input register, its parse step runs in the cycle it leaves, and the result is
// shown from the output register in the cycle after that.
// Reset (synchronous, active low) empties both registers and puts the parser idle.
// A stalled result holds the parse step; the input register still takes one
// more transaction, so the source keeps moving until both registers are full.
module spectral_section_parser
    import spp_pkg::*;
#(
    parameter int MAX_BANDS = DEF_MAX_BANDS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    spp_in_if.sink         i_in,
    spp_out_if.source      o_out
);
    t_in_item in_item;
    t_in_item stage_item;
    t_result  core_res;
    t_result  out_res;
    logic     adv;
    logic     take;
    logic     res_fire;

    // Pack the input channel payload
    assign in_item.action          = i_in.action;
    assign in_item.stream_bit      = i_in.stream_bit;
    assign in_item.max_bands       = i_in.max_bands;
    assign in_item.band_count      = i_in.band_count;
    assign in_item.short_transform = i_in.short_transform;

    // Input register: advance whenever the output register can take a result
    spp_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_item  (in_item),
        .i_take  (take),
        .o_adv   (adv),
        .o_item  (stage_item)
    );

    // Parse step: update group state, form at most one result per item
    spp_parse_core #(
        .MAX_BANDS (MAX_BANDS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_item     (stage_item),
        .o_res_fire (res_fire),
        .o_res      (core_res)
    );

    // Result register: hold until the sink takes it
    spp_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_fire  (res_fire),
        .i_res   (core_res),
        .o_take  (take),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_res   (out_res)
    );

    // Unpack the result payload
    assign o_out.section_valid    = out_res.section_valid;
    assign o_out.section_codebook = out_res.section_codebook;
    assign o_out.section_start    = out_res.section_start;
    assign o_out.section_end      = out_res.section_end;
    assign o_out.group_done       = out_res.group_done;
    assign o_out.limit_sections   = out_res.limit_sections;
    assign o_out.error_code       = out_res.error_code;
endmodule

>>> rtl/core/spp_checker.sv
module spp_checker
    import spp_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic               i_section_valid,
    input logic [START_W-1:0] i_section_start,
    input logic [BAND_W-1:0]  i_section_end,
    input logic               i_group_done,
    input logic [BAND_W-1:0]  i_limit_sections,
    input logic [ERR_W-1:0]   i_error_code
);
    // Stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_section_end)
            && $stable(i_error_code) && $stable(i_group_done))
        else $error("result changed while stalled");

    // Every result is a section or a group end
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_section_valid || i_group_done)
        else $error("result is neither section nor group end");

    // Error results end the group and carry no section
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_error_code != ERR_NONE |-> i_group_done && !i_section_valid
            && i_limit_sections == '0
            && (i_error_code == ERR_CODEBOOK || i_error_code == ERR_PAST_MAX))
        else $error("malformed error result");

    // Sections are never empty
    a_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_section_valid |-> i_section_end > {1'b0, i_section_start})
        else $error("empty section");
endmodule

bind spectral_section_parser spp_checker u_spp_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_section_valid  (o_out.section_valid),
    .i_section_start  (o_out.section_start),
    .i_section_end    (o_out.section_end),
    .i_group_done     (o_out.group_done),
    .i_limit_sections (o_out.limit_sections),
    .i_error_code     (o_out.error_code)
);

>>> dv/spectral_section_parser_checker.sv
module spectral_section_parser_checker
    import spp_pkg::*;
#(
    parameter int MAX_BANDS = DEF_MAX_BANDS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    spp_in_if    i_in_ch,
    spp_out_if   i_out_ch,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked,
    output int   o_flagged
);
    timeunit 1ns;
    timeprecision 1ps;

    t_result section_results[$];

    // shadow of the parser state
    t_phase          grp_phase    = PH_IDLE;
    int              grp_bit_cnt  = 0;
    logic [CB_W-1:0] cb_bits      = '0;
    logic [INC_W-1:0] inc_bits    = '0;
    int              len_sum      = 1;
    int              band_pos     = 0;
    int              sec_total    = 0;
    int              sec_at_limit = 0;
    int              grp_max      = 0;
    int              grp_bands    = 0;
    logic            grp_short    = 1'b0;

    int fails   = 0;
    int checked = 0;
    int flagged = 0;

    // append one predicted result at the tail of the queue
    function automatic void queue_expected(t_result r);
        section_results.insert(section_results.size(), r);
    endfunction

    function automatic void parse_step(t_in_item it);
        t_result r;
        int      nbits;
        int      esc;
        int      incr;
        int      len;
        int      sec_end;
        r     = '0;
        nbits = grp_short ? int'(NBITS_SHORT) : int'(NBITS_LONG);
        esc   = grp_short ? int'(ESC_SHORT) : int'(ESC_LONG);

        if (it.action == ACT_START) begin
            grp_max   = (it.max_bands > MAX_BANDS) ? MAX_BANDS : int'(it.max_bands);
            grp_bands = (it.band_count > MAX_BANDS) ? MAX_BANDS : int'(it.band_count);
            grp_short = it.short_transform;
            band_pos     = 0;
            sec_total    = 0;
            sec_at_limit = 0;
            grp_bit_cnt  = 0;
            cb_bits      = '0;
            inc_bits     = '0;
            len_sum      = 1;
            if (grp_max == 0) begin
                grp_phase    = PH_IDLE;
                r.group_done = 1'b1;
                queue_expected(r);
            end else begin
                grp_phase = PH_CODEBOOK;
            end
            return;
        end

        case (grp_phase)
            PH_CODEBOOK: begin
                cb_bits = {cb_bits[CB_W-2:0], it.stream_bit};
                grp_bit_cnt++;
                if (grp_bit_cnt >= CB_W) begin
                    grp_phase   = PH_LENGTH;
                    grp_bit_cnt = 0;
                    inc_bits    = '0;
                    len_sum     = 1;
                end
            end
            PH_LENGTH: begin
                inc_bits = {inc_bits[INC_W-2:0], it.stream_bit};
                grp_bit_cnt++;
                if (grp_bit_cnt < nbits)
                    return;
                incr        = int'(inc_bits) & esc;
                grp_bit_cnt = 0;
                inc_bits    = '0;
                if (incr == esc) begin
                    len_sum = (len_sum + esc > 127) ? 127 : len_sum + esc;
                    return;
                end
                len     = (len_sum + incr > 127) ? 127 : len_sum + incr;
                len_sum = 1;
                r.group_done = 1'b1;
                if (cb_bits > CB_MAX) begin
                    grp_phase    = PH_IDLE;
                    r.error_code = ERR_CODEBOOK;
                    queue_expected(r);
                    return;
                end
                sec_end = band_pos + len;
                if (sec_end > grp_max) begin
                    grp_phase    = PH_IDLE;
                    r.error_code = ERR_PAST_MAX;
                    queue_expected(r);
                    return;
                end
                sec_total = (sec_total + 1) & 127;
                if (band_pos < grp_bands && sec_end >= grp_bands)
                    sec_at_limit = sec_total;
                r.section_valid    = 1'b1;
                r.section_codebook = cb_bits;
                r.section_start    = START_W'(band_pos);
                r.section_end      = BAND_W'(sec_end);
                band_pos = sec_end;
                cb_bits  = '0;
                if (sec_end == grp_max) begin
                    grp_phase = PH_IDLE;
                    r.limit_sections = BAND_W'((sec_at_limit != 0) ? sec_at_limit : sec_total);
                end else begin
                    grp_phase    = PH_CODEBOOK;
                    r.group_done = 1'b0;
                end
                queue_expected(r);
            end
            default: ;  // stream bit outside a group: dropped
        endcase
    endfunction

    function automatic bit field_ok(string name, int want, int got);
        if (want == got)
            return 1'b1;
        $error("%s: expected %0d, got %0d", name, want, got);
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin
        t_in_item it;
        t_result  want;
        bit       ok;
        if (!i_rst_n) begin
            section_results.delete();
            grp_phase    = PH_IDLE;
            grp_bit_cnt  = 0;
            cb_bits      = '0;
            inc_bits     = '0;
            len_sum      = 1;
            band_pos     = 0;
            sec_total    = 0;
            sec_at_limit = 0;
            grp_max      = 0;
            grp_bands    = 0;
            grp_short    = 1'b0;
        end else begin
            // results always leave after their item has been taken, so compare first
            if (i_out_ch.valid && i_out_ch.ready) begin
                if (section_results.size() == 0) begin
                    $error("result with no pending expectation");
                    fails++;
                end else begin
                    want = section_results.pop_front();
                    ok = field_ok("section_valid", want.section_valid,
                                  i_out_ch.section_valid)
                       & field_ok("section_codebook", want.section_codebook,
                                  i_out_ch.section_codebook)
                       & field_ok("section_start", want.section_start,
                                  i_out_ch.section_start)
                       & field_ok("section_end", want.section_end,
                                  i_out_ch.section_end)
                       & field_ok("group_done", want.group_done,
                                  i_out_ch.group_done)
                       & field_ok("limit_sections", want.limit_sections,
                                  i_out_ch.limit_sections)
                       & field_ok("error_code", want.error_code,
                                  i_out_ch.error_code);
                    if (!ok)
                        fails++;
                    checked++;
                    if (want.error_code != ERR_NONE)
                        flagged++;
                end
            end
            if (i_in_ch.valid && i_in_ch.ready) begin
                it.action          = i_in_ch.action;
                it.stream_bit      = i_in_ch.stream_bit;
                it.max_bands       = i_in_ch.max_bands;
                it.band_count      = i_in_ch.band_count;
                it.short_transform = i_in_ch.short_transform;
                parse_step(it);
            end
        end
        o_fail_count <= fails;
        o_pending    <= section_results.size();
        o_checked    <= checked;
        o_flagged    <= flagged;
    end

endmodule

>>> dv/spectral_section_parser_tb.sv
module spectral_section_parser_tb
    import spp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Budget: ~1500 items plus result stalls and one long hold-off come to a run
    // far shorter than the limit.
    localparam int CYCLE_LIMIT  = 400000;
    localparam int STALL_CYCLES = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int ITEM_TARGET  = 1400;

    logic clk = 1'b0;
    logic rst_n;

    spp_in_if  in_ch ();
    spp_out_if out_ch ();

    int fail_count;
    int pending;
    int checked;
    int flagged;

    int sent_items   = 0;
    int cycle_count  = 0;
    int src_idle_pct = 14;
    int snk_idle_pct = 68;
    bit stall_request = 1'b0;
    bit stall_done    = 1'b0;
    bit pause_done    = 1'b0;

    spectral_section_parser uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    spectral_section_parser_checker chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_ch      (in_ch),
        .i_out_ch     (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_flagged    (flagged)
    );

    always #1 clk = ~clk;

    // Watchdog: a hung handshake must not hang the run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** spectral_section_parser: FAILED **");
            $finish;
        end
    end

    // Result sink: random back-pressure, plus one long hold-off on request.
    // The hold-off is counted here so the sender keeps offering meanwhile.
    initial begin : result_sink
        int hold_left;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (stall_request) begin
                stall_request = 1'b0;
                out_ch.ready <= 1'b0;
                for (hold_left = STALL_CYCLES; hold_left > 0; hold_left--)
                    @(posedge clk);
            end
            out_ch.ready <= !(snk_idle_pct != 0 && $urandom_range(99) < snk_idle_pct);
        end
    end

    // Offer one transaction and hold it until accepted. Idle cycles go in
    // before the offer so valid never drops and rises in the same step.
    task automatic drive_item(input logic act, input logic sbit,
                              input logic [START_W-1:0] mb,
                              input logic [BAND_W-1:0] bc,
                              input logic st, input bit counted);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.action          <= act;
        in_ch.stream_bit      <= sbit;
        in_ch.max_bands       <= mb;
        in_ch.band_count      <= bc;
        in_ch.short_transform <= st;
        do @(posedge clk); while (!in_ch.ready);
        if (counted)
            sent_items++;
    endtask

    // Unused fields carry random junk so every payload bit toggles.
    task automatic send_bit(input bit b, input bit counted);
        drive_item(ACT_BIT, b, START_W'($urandom), BAND_W'($urandom),
                   1'($urandom), counted);
    endtask

    task automatic send_start(input int mb, input int bc, input bit st);
        drive_item(ACT_START, 1'($urandom), START_W'(mb), BAND_W'(bc), st, 1'b1);
    endtask

    // Send a value MSB first.
    task automatic send_field(input int value, input int nbits);
        int i;
        for (i = nbits - 1; i >= 0; i--)
            send_bit(value[i], 1'b1);
    endtask

    // Encode one section: codebook, then escaped length increments.
    // Lengths above 127 still encode fine and drive the accumulator into saturation.
    task automatic send_section(input int cb, input int len, input bit st);
        int esc;
        int nb;
        int rest;
        esc  = st ? int'(ESC_SHORT) : int'(ESC_LONG);
        nb   = st ? int'(NBITS_SHORT) : int'(NBITS_LONG);
        rest = len - 1;
        send_field(cb, CB_W);
        while (rest >= esc) begin
            send_field(esc, nb);
            rest -= esc;
        end
        send_field(rest, nb);
    endtask

    // Stop offering and wait for every predicted result to come back.
    // The first edge lets the checker's pending count catch up.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // One window group: mostly well-formed sections with random content,
    // some abandoned mid-stream, some ending in each kind of error.
    task automatic random_group();
        int m;
        int b;
        int pos;
        int len;
        int cb;
        int pick;
        int k;
        bit st;
        bit ended;
        st = 1'($urandom_range(1));
        if ($urandom_range(30) == 0)
            m = 0;
        else if ($urandom_range(12) == 0)
            m = 63;
        else
            m = $urandom_range(1, 20);
        b = ($urandom_range(3) == 0) ? $urandom_range(127) : $urandom_range(m + 2);
        send_start(m, b, st);
        pos   = 0;
        ended = (m == 0);
        while (!ended) begin
            pick = $urandom_range(99);
            if (pick < 3) begin
                // abandon: a few stray bits, then the next start restarts
                for (k = $urandom_range(7); k > 0; k--)
                    send_bit(1'($urandom_range(1)), 1'b1);
                return;
            end
            cb = $urandom_range(11);
            if (pick < 6) begin
                cb  = $urandom_range(12, 15);
                len = $urandom_range(1, m - pos);
            end else if (pick < 9) begin
                len = m - pos + $urandom_range(1, 20);
            end else if (pick < 11) begin
                len = $urandom_range(128, 200);
            end else if ($urandom_range(5) == 0) begin
                len = $urandom_range(1, m - pos);
            end else begin
                len = $urandom_range(1, (m - pos < 6) ? m - pos : 6);
            end
            send_section(cb, len, st);
            pos  += len;
            ended = (pick < 11) || (pos == m);
        end
        // occasional bits between groups, which the parser drops
        if ($urandom_range(7) == 0)
            for (k = $urandom_range(1, 3); k > 0; k--)
                send_bit(1'($urandom_range(1)), 1'b0);
    endtask

    initial begin : stimulus
        rst_n                 <= 1'b0;
        in_ch.valid           <= 1'b0;
        in_ch.action          <= ACT_START;
        in_ch.stream_bit      <= 1'b0;
        in_ch.max_bands       <= '0;
        in_ch.band_count      <= '0;
        in_ch.short_transform <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: bit with no open group, empty group with an oversized
        // band count, restart in mid-codebook, bad codebook, section past max.
        send_bit(1'b1, 1'b0);
        send_start(0, 127, 1'b1);
        send_start(63, 64, 1'b0);
        send_bit(1'b1, 1'b1);
        send_bit(1'b0, 1'b1);
        send_start(1, 1, 1'b1);
        send_section(15, 1, 1'b1);
        send_start(3, 2, 1'b1);
        send_section(11, 4, 1'b1);

        // Random: light source idling with a choked sink, then the reverse,
        // then full rate on both sides.
        while (sent_items < ITEM_TARGET) begin
            if (sent_items >= 2 * ITEM_TARGET / 3) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end else if (sent_items >= ITEM_TARGET / 3) begin
                src_idle_pct = 68;
                snk_idle_pct = 14;
            end
            if (!stall_done && sent_items >= 200) begin
                stall_request = 1'b1;
                stall_done    = 1'b1;
            end
            if (!pause_done && sent_items >= 600) begin
                wait_drained();
                pause_done = 1'b1;
            end
            random_group();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d input items; checked %0d results, %0d of them error reports.",
                 sent_items, checked, flagged);
        $display("Covered both increment widths, escapes, saturation, restarts and stalls.");
        if (fail_count == 0 && pending == 0)
            $display("** spectral_section_parser: PASSED **");
        else
            $display("** spectral_section_parser: FAILED **");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/spp_pkg.sv
rtl/core/spp_in_if.sv
rtl/core/spp_out_if.sv
rtl/core/spp_in_stage.sv
rtl/core/spp_parse_core.sv
rtl/core/spp_out_stage.sv
rtl/core/spectral_section_parser.sv
rtl/core/spp_checker.sv
dv/spectral_section_parser_checker.sv
dv/spectral_section_parser_tb.sv
